@@ hw/rtl/spp_pkg.sv @@
package spp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SAT_W     = 68;
  localparam int SQ_IN_W   = 64;
  localparam int SQ_OUT_W  = SQ_IN_W / 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTRE_X = 3'd2,
    REG_CENTRE_Y = 3'd3,
    REG_HOMOG_W  = 3'd4
  } cfg_reg_e;

  // Magnitude of a signed Q value; the most negative value maps to 2^31.
  function automatic logic [Q_W-1:0] mag_q(input logic signed [Q_W-1:0] v);
    mag_q = v[Q_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Clamp a wide signed value to the signed Q range.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7FFF_FFFF);
    lo = SAT_W'(-32'sh7FFF_FFFF - 32'sd1);
    if (v > hi) begin
      sat_q = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat_q = 32'sh8000_0000;
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/spp_div.sv @@
// Unsigned restoring divider, one quotient bit per pipeline stage.
module spp_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  localparam int AW = DEN_W + NUM_W;

  logic [AW-1:0]    acc_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [AW-1:0]    acc_d [NUM_W];

  always_comb begin
    for (int k = 0; k < NUM_W; k++) begin
      logic [AW-1:0]    acc_in;
      logic [DEN_W-1:0] den_in;
      logic [AW:0]      sh;
      logic [DEN_W:0]   hi;
      logic             ge;
      if (k == 0) begin
        acc_in = {{DEN_W{1'b0}}, num_i};
        den_in = den_i;
      end else begin
        acc_in = acc_q[k-1];
        den_in = den_q[k-1];
      end
      sh = {acc_in, 1'b0};
      hi = sh[AW:NUM_W];
      ge = (hi >= {1'b0, den_in});
      if (ge) begin
        hi = hi - {1'b0, den_in};
      end
      acc_d[k] = {hi[DEN_W-1:0], sh[NUM_W-1:1], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_W; k++) begin
      acc_q[k] <= acc_d[k];
      den_q[k] <= (k == 0) ? den_i : den_q[k-1];
    end
  end

  assign quo_o = acc_q[NUM_W-1][NUM_W-1:0];

endmodule

@@ hw/rtl/spp_sqrt.sv @@
// Integer square root, one result bit per pipeline stage.
module spp_sqrt (
  input  logic                         clk_i,
  input  logic [spp_pkg::SQ_IN_W-1:0]  rad_i,
  output logic [spp_pkg::SQ_OUT_W-1:0] root_o
);

  localparam int IW = spp_pkg::SQ_IN_W;
  localparam int OW = spp_pkg::SQ_OUT_W;
  localparam int RW = OW + 2;

  logic [IW-1:0] rad_q  [OW];
  logic [RW-1:0] rem_q  [OW];
  logic [OW-1:0] root_q [OW];
  logic [RW-1:0] rem_d  [OW];
  logic [OW-1:0] root_d [OW];

  always_comb begin
    for (int k = 0; k < OW; k++) begin
      logic [IW-1:0] rad_in;
      logic [RW-1:0] rem_in;
      logic [OW-1:0] root_in;
      logic [RW+1:0] rem_sh;
      logic [RW+1:0] trial;
      if (k == 0) begin
        rad_in  = rad_i;
        rem_in  = '0;
        root_in = '0;
      end else begin
        rad_in  = rad_q[k-1];
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
      end
      rem_sh = {rem_in, rad_in[IW-1:IW-2]};
      trial  = {2'b00, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_sh    = rem_sh - trial;
        root_d[k] = {root_in[OW-2:0], 1'b1};
      end else begin
        root_d[k] = {root_in[OW-2:0], 1'b0};
      end
      rem_d[k] = rem_sh[RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < OW; k++) begin
      rad_q[k]  <= (k == 0) ? (rad_i << 2) : (rad_q[k-1] << 2);
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
    end
  end

  assign root_o = root_q[OW-1];

endmodule

@@ hw/rtl/stereographic_point_project.sv @@
// Stereographic point projection with a 2x2 Jacobian, signed fixed point.
// A request is a scene point (scene_x_i, scene_y_i, scene_z_i), taken at a
// rising edge where start is high and busy is low. busy stays low, so one
// request may be issued in every clock cycle. Each result appears on the
// output ports for exactly one cycle, flagged by done_o, in request order.
// A result passes through the 32+F stage quotient divider, the 32 stage
// square root, the 2F+2 stage divider for d and the 64 stage dividers for
// the Jacobian terms, plus the surrounding register stages.
// Throughput is one point per clock: every divider and the square root are
// fully pipelined, one quotient or root bit per stage.
// A zero Z yields status_o = 1 and zeros on all other fields.
// The configuration port writes focal_x, focal_y, centre_x, centre_y and homog_w
// by index; the user writes only while no request is in flight, unenforced by the block.
// Reset clears the pipeline valid bits and loads the default registers.
// The receiver cannot stall, so no backpressure exists and nothing waits.
module stereographic_point_project #(
  parameter int FRAC_BITS = spp_pkg::FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [spp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spp_pkg::Q_W-1:0]       cfg_wdata_i,
  input  logic signed [31:0]            scene_x_i,
  input  logic signed [31:0]            scene_y_i,
  input  logic signed [31:0]            scene_z_i,
  output logic                          done_o,
  output logic signed [31:0]            image_x_o,
  output logic signed [31:0]            image_y_o,
  output logic signed [31:0]            image_w_o,
  output logic signed [31:0]            jac_xx_o,
  output logic signed [31:0]            jac_xy_o,
  output logic signed [31:0]            jac_yx_o,
  output logic signed [31:0]            jac_yy_o,
  output logic                          status_o
);

  localparam int F     = FRAC_BITS;
  localparam int SAT_W = spp_pkg::SAT_W;
  localparam int N1    = 32 + F;
  localparam int N2    = 2 * F + 2;
  localparam int D2    = 33;
  localparam int LS    = spp_pkg::SQ_OUT_W;
  localparam int N3    = 64;
  localparam int D3    = 33;
  localparam logic [63:0]   ONE_SQ = 64'd1 << (2 * F);
  localparam logic [N2-1:0] TWO_SQ = {1'b1, {(N2-1){1'b0}}};
  localparam logic [D2-1:0] ONE_D  = D2'(1) << F;
  localparam logic [F:0]    ONE_C  = {1'b1, {F{1'b0}}};

  typedef struct packed {
    logic zero;
    logic negx;
    logic negy;
  } seg1_t;

  typedef struct packed {
    logic               zero;
    logic signed [31:0] xz;
    logic signed [31:0] yz;
  } seg2_t;

  typedef struct packed {
    logic               zero;
    logic signed [31:0] xz;
    logic signed [31:0] yz;
    logic [31:0]        s;
  } seg3_t;

  typedef struct packed {
    logic               zero;
    logic               cneg;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] ix;
    logic signed [31:0] iy;
  } seg4_t;

  // Saturate a normalized quotient magnitude with its sign.
  function automatic logic signed [31:0] quo_sat(input logic [N1-1:0] q, input logic neg);
    if (neg) begin
      quo_sat = (q > N1'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
    end else begin
      quo_sat = (q > N1'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end
  endfunction

  function automatic logic [F:0] clamp_one(input logic [N3-1:0] q);
    clamp_one = (q > N3'(ONE_C)) ? ONE_C : q[F:0];
  endfunction

  // Configuration registers.
  logic signed [31:0] focal_x_q, focal_y_q, centre_x_q, centre_y_q, homog_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 32'sd1 <<< F;
      focal_y_q  <= 32'sd1 <<< F;
      centre_x_q <= '0;
      centre_y_q <= '0;
      homog_w_q  <= 32'sd1 <<< F;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spp_pkg::REG_FOCAL_X:  focal_x_q  <= cfg_wdata_i;
        spp_pkg::REG_FOCAL_Y:  focal_y_q  <= cfg_wdata_i;
        spp_pkg::REG_CENTRE_X: centre_x_q <= cfg_wdata_i;
        spp_pkg::REG_CENTRE_Y: centre_y_q <= cfg_wdata_i;
        spp_pkg::REG_HOMOG_W:  homog_w_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline never holds off a request.
  assign busy = 1'b0;

  // Valid bits of every stage and delay line.
  logic          a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q, g_vld_q, h_vld_q, i_vld_q;
  logic          out_vld_q;
  logic [N1-1:0] v1_q;
  logic [LS-1:0] v2_q;
  logic [N2-1:0] v3_q;
  logic [N3-1:0] v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      g_vld_q   <= 1'b0;
      h_vld_q   <= 1'b0;
      i_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      v1_q      <= '0;
      v2_q      <= '0;
      v3_q      <= '0;
      v4_q      <= '0;
    end else begin
      a_vld_q   <= start && !busy;
      v1_q      <= {v1_q[N1-2:0], a_vld_q};
      b_vld_q   <= v1_q[N1-1];
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      v2_q      <= {v2_q[LS-2:0], d_vld_q};
      e_vld_q   <= v2_q[LS-1];
      v3_q      <= {v3_q[N2-2:0], e_vld_q};
      g_vld_q   <= v3_q[N2-1];
      h_vld_q   <= g_vld_q;
      v4_q      <= {v4_q[N3-2:0], h_vld_q};
      i_vld_q   <= v4_q[N3-1];
      out_vld_q <= i_vld_q;
    end
  end

  // Stage A: capture the request.
  logic signed [31:0] a_x_q, a_y_q, a_z_q;

  always_ff @(posedge clk_i) begin
    a_x_q <= scene_x_i;
    a_y_q <= scene_y_i;
    a_z_q <= scene_z_i;
  end

  // Normalization by Z: one divider for each of X and Y.
  logic [N1-1:0] qx, qy;

  spp_div #(.NUM_W(N1), .DEN_W(32)) u_div_x (
    .clk_i (clk_i),
    .num_i ({spp_pkg::mag_q(a_x_q), {F{1'b0}}}),
    .den_i (spp_pkg::mag_q(a_z_q)),
    .quo_o (qx)
  );

  spp_div #(.NUM_W(N1), .DEN_W(32)) u_div_y (
    .clk_i (clk_i),
    .num_i ({spp_pkg::mag_q(a_y_q), {F{1'b0}}}),
    .den_i (spp_pkg::mag_q(a_z_q)),
    .quo_o (qy)
  );

  seg1_t p1_q [N1];
  seg1_t p1_in;

  assign p1_in = '{zero: (a_z_q == 32'sd0),
                   negx: a_x_q[31] ^ a_z_q[31],
                   negy: a_y_q[31] ^ a_z_q[31]};

  // Stages B to D: saturate the quotients, square them and form 1 + R2.
  logic               b_zero_q, c_zero_q, d_zero_q;
  logic signed [31:0] b_xz_q, b_yz_q, c_xz_q, c_yz_q, d_xz_q, d_yz_q;
  logic [63:0]        c_sqx_q, c_sqy_q, d_rad_q;
  logic [31:0]        mxz_b, myz_b;

  assign mxz_b = spp_pkg::mag_q(b_xz_q);
  assign myz_b = spp_pkg::mag_q(b_yz_q);

  always_ff @(posedge clk_i) begin
    p1_q[0] <= p1_in;
    for (int k = 1; k < N1; k++) begin
      p1_q[k] <= p1_q[k-1];
    end
    b_zero_q <= p1_q[N1-1].zero;
    b_xz_q   <= quo_sat(qx, p1_q[N1-1].negx);
    b_yz_q   <= quo_sat(qy, p1_q[N1-1].negy);
    c_zero_q <= b_zero_q;
    c_xz_q   <= b_xz_q;
    c_yz_q   <= b_yz_q;
    c_sqx_q  <= 64'(mxz_b) * 64'(mxz_b);
    c_sqy_q  <= 64'(myz_b) * 64'(myz_b);
    d_zero_q <= c_zero_q;
    d_xz_q   <= c_xz_q;
    d_yz_q   <= c_yz_q;
    d_rad_q  <= c_sqx_q + c_sqy_q + ONE_SQ;
  end

  // Square root of 1 + R2.
  logic [31:0] s_root;

  spp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (d_rad_q),
    .root_o (s_root)
  );

  seg2_t p2_q [LS];

  // Stage E: denominator of d.
  logic               e_zero_q;
  logic signed [31:0] e_xz_q, e_yz_q;
  logic [31:0]        e_s_q;
  logic [D2-1:0]      e_den_q;

  always_ff @(posedge clk_i) begin
    p2_q[0] <= '{zero: d_zero_q, xz: d_xz_q, yz: d_yz_q};
    for (int k = 1; k < LS; k++) begin
      p2_q[k] <= p2_q[k-1];
    end
    e_zero_q <= p2_q[LS-1].zero;
    e_xz_q   <= p2_q[LS-1].xz;
    e_yz_q   <= p2_q[LS-1].yz;
    e_s_q    <= s_root;
    e_den_q  <= {1'b0, s_root} + ONE_D;
  end

  // d = 2 / (1 + s).
  logic [N2-1:0] qd;

  spp_div #(.NUM_W(N2), .DEN_W(D2)) u_div_d (
    .clk_i (clk_i),
    .num_i (TWO_SQ),
    .den_i (e_den_q),
    .quo_o (qd)
  );

  seg3_t p3_q [N2];

  // Stage G: scale focal lengths and normalized coordinates by d.
  logic signed [F+1:0]  dd;
  logic signed [F+33:0] txw, tyw, uw, vw;
  logic                 g_zero_q;
  logic signed [31:0]   g_xz_q, g_yz_q, g_tx_q, g_ty_q, g_u_q, g_v_q;
  logic [31:0]          g_s_q;

  assign dd  = $signed({1'b0, qd[F:0]});
  assign txw = dd * focal_x_q;
  assign tyw = dd * focal_y_q;
  assign uw  = dd * p3_q[N2-1].xz;
  assign vw  = dd * p3_q[N2-1].yz;

  // Stage H: the wide products for the image point and the Jacobian.
  logic               h_zero_q, h_cneg_q;
  logic signed [31:0] h_tx_q, h_ty_q;
  logic signed [63:0] h_px_q, h_py_q;
  logic [63:0]        h_exn_q, h_eyn_q, h_cn_q;
  logic [31:0]        h_s_q;
  logic [31:0]        mxz_g, myz_g, mu_g, mv_g;

  assign mxz_g = spp_pkg::mag_q(g_xz_q);
  assign myz_g = spp_pkg::mag_q(g_yz_q);
  assign mu_g  = spp_pkg::mag_q(g_u_q);
  assign mv_g  = spp_pkg::mag_q(g_v_q);

  always_ff @(posedge clk_i) begin
    p3_q[0] <= '{zero: e_zero_q, xz: e_xz_q, yz: e_yz_q, s: e_s_q};
    for (int k = 1; k < N2; k++) begin
      p3_q[k] <= p3_q[k-1];
    end
    g_zero_q <= p3_q[N2-1].zero;
    g_xz_q   <= p3_q[N2-1].xz;
    g_yz_q   <= p3_q[N2-1].yz;
    g_s_q    <= p3_q[N2-1].s;
    g_tx_q   <= txw[F+31:F];
    g_ty_q   <= tyw[F+31:F];
    g_u_q    <= uw[F+31:F];
    g_v_q    <= vw[F+31:F];
    h_zero_q <= g_zero_q;
    h_cneg_q <= g_u_q[31] ^ g_v_q[31];
    h_tx_q   <= g_tx_q;
    h_ty_q   <= g_ty_q;
    h_s_q    <= g_s_q;
    h_px_q   <= g_tx_q * g_xz_q;
    h_py_q   <= g_ty_q * g_yz_q;
    h_exn_q  <= 64'(mxz_g) * 64'(mu_g);
    h_eyn_q  <= 64'(myz_g) * 64'(mv_g);
    h_cn_q   <= 64'(mu_g) * 64'(mv_g);
  end

  // Jacobian correction terms, each divided by 2s.
  logic [N3-1:0] qex, qey, qc;

  spp_div #(.NUM_W(N3), .DEN_W(D3)) u_div_ex (
    .clk_i (clk_i),
    .num_i (h_exn_q),
    .den_i ({h_s_q, 1'b0}),
    .quo_o (qex)
  );

  spp_div #(.NUM_W(N3), .DEN_W(D3)) u_div_ey (
    .clk_i (clk_i),
    .num_i (h_eyn_q),
    .den_i ({h_s_q, 1'b0}),
    .quo_o (qey)
  );

  spp_div #(.NUM_W(N3), .DEN_W(D3)) u_div_c (
    .clk_i (clk_i),
    .num_i (h_cn_q),
    .den_i ({h_s_q, 1'b0}),
    .quo_o (qc)
  );

  // The image point is finished here and waits alongside the dividers.
  seg4_t p4_q [N3];
  logic signed [SAT_W-1:0] ixw, iyw;

  assign ixw = SAT_W'(h_px_q >>> F) + SAT_W'(centre_x_q);
  assign iyw = SAT_W'(h_py_q >>> F) + SAT_W'(centre_y_q);

  // Stage I: clamp the terms to one and form 1 - e and the signed cross term.
  logic               i_zero_q;
  logic signed [31:0] i_tx_q, i_ty_q, i_ix_q, i_iy_q;
  logic signed [F+1:0] i_omx_q, i_omy_q, i_c_q;
  logic [F:0]         cm;

  assign cm = clamp_one(qc);

  // Stage J: Jacobian products and the result registers.
  logic signed [F+33:0]  jxxw, jyyw, jxyw, jyxw;
  logic signed [31:0]    out_ix_q, out_iy_q, out_iw_q;
  logic signed [31:0]    out_jxx_q, out_jxy_q, out_jyx_q, out_jyy_q;
  logic                  out_st_q;

  assign jxxw = i_tx_q * i_omx_q;
  assign jyyw = i_ty_q * i_omy_q;
  assign jxyw = focal_x_q * i_c_q;
  assign jyxw = focal_y_q * i_c_q;

  always_ff @(posedge clk_i) begin
    p4_q[0] <= '{zero: h_zero_q, cneg: h_cneg_q, tx: h_tx_q, ty: h_ty_q,
                 ix: spp_pkg::sat_q(ixw), iy: spp_pkg::sat_q(iyw)};
    for (int k = 1; k < N3; k++) begin
      p4_q[k] <= p4_q[k-1];
    end
    i_zero_q <= p4_q[N3-1].zero;
    i_tx_q   <= p4_q[N3-1].tx;
    i_ty_q   <= p4_q[N3-1].ty;
    i_ix_q   <= p4_q[N3-1].ix;
    i_iy_q   <= p4_q[N3-1].iy;
    i_omx_q  <= $signed({1'b0, ONE_C}) - $signed({1'b0, clamp_one(qex)});
    i_omy_q  <= $signed({1'b0, ONE_C}) - $signed({1'b0, clamp_one(qey)});
    i_c_q    <= p4_q[N3-1].cneg ? -$signed({1'b0, cm}) : $signed({1'b0, cm});

    if (i_zero_q) begin
      out_ix_q  <= '0;
      out_iy_q  <= '0;
      out_iw_q  <= '0;
      out_jxx_q <= '0;
      out_jxy_q <= '0;
      out_jyx_q <= '0;
      out_jyy_q <= '0;
    end else begin
      out_ix_q  <= i_ix_q;
      out_iy_q  <= i_iy_q;
      out_iw_q  <= homog_w_q;
      out_jxx_q <= spp_pkg::sat_q(SAT_W'(jxxw >>> F));
      out_jyy_q <= spp_pkg::sat_q(SAT_W'(jyyw >>> F));
      out_jxy_q <= spp_pkg::sat_q(-SAT_W'(jxyw >>> F));
      out_jyx_q <= spp_pkg::sat_q(-SAT_W'(jyxw >>> F));
    end
    out_st_q <= i_zero_q;
  end

  assign done_o    = out_vld_q;
  assign image_x_o = out_ix_q;
  assign image_y_o = out_iy_q;
  assign image_w_o = out_iw_q;
  assign jac_xx_o  = out_jxx_q;
  assign jac_xy_o  = out_jxy_q;
  assign jac_yx_o  = out_jyx_q;
  assign jac_yy_o  = out_jyy_q;
  assign status_o  = out_st_q;

endmodule
